@@ sv/c8ic_pkg.sv @@
// Shared types, constants and the hex font for the CHIP-8 instruction core.
package c8ic_pkg;

  localparam int MEM_BYTES     = 4096;
  localparam int ADDR_W        = $clog2(MEM_BYTES);
  localparam int STACK_ENTRIES = 16;
  localparam int STK_W         = $clog2(STACK_ENTRIES);
  localparam int DEPTH_W       = $clog2(STACK_ENTRIES + 1);
  localparam int SCR_W         = 64;
  localparam int SCR_H         = 32;
  localparam int ROW_W         = $clog2(SCR_H);
  localparam int COL_W         = $clog2(SCR_W);
  localparam int REG_CNT       = 16;
  localparam int KEY_CNT       = 16;
  localparam int FONT_BYTES    = 80;
  localparam int CFG_IDX_W     = 3;

  localparam logic [ADDR_W-1:0] PC_RESET = 12'h200;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_VF   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_VX   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEEP_INDEX = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_X     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WRAP       = 3'd4;

  localparam logic [7:0] FONT [0:FONT_BYTES-1] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  typedef enum logic [2:0] {
    MODE_EXEC, MODE_TICK, MODE_KEY_DOWN, MODE_KEY_UP,
    MODE_MEM_WR, MODE_MEM_RD, MODE_ROW_RD, MODE_NOP
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK, ST_UNKNOWN, ST_KEY_WAIT, ST_OVERFLOW, ST_UNDERFLOW
  } status_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_TICK, S_KEY, S_MWR, S_MRD, S_CAPRB, S_FBRD, S_CAPROW,
    S_FHI, S_FLO, S_RX, S_RY, S_EXEC, S_WRF, S_RET, S_DRD, S_DWR,
    S_B0, S_B1, S_B2, S_K55R, S_K55W, S_K65R, S_K65W, S_KEND, S_DONE
  } state_t;

  typedef enum logic [4:0] {
    C_NONE, C_CLEAR, C_LATCH, C_TICK, C_KEY, C_MWR, C_MRD, C_CAPRB, C_FBRD,
    C_CAPROW, C_FHI, C_FLO, C_RX, C_RY, C_EXEC, C_WRF, C_RET, C_DRD, C_DWR,
    C_B0, C_B1, C_B2, C_K55R, C_K55W, C_K65R, C_K65W, C_KEND, C_OUT
  } cmd_t;

  typedef enum logic [2:0] {
    K_SIMPLE, K_FLAG, K_DRAW, K_BCD, K_RET, K_BLK_ST, K_BLK_LD
  } kind_t;

  typedef struct packed {
    logic  clr_last;
    kind_t kind;
    logic  draw_end;
    logic  loop_last;
  } dp_stat_t;

endpackage

@@ sv/c8ic_if.sv @@
// Valid/ready channel interfaces for the input and result items.
interface c8ic_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [11:0] address;
  logic [7:0]  data;
  logic [7:0]  random_byte;
  modport source (output valid, mode, address, data, random_byte, input ready);
  modport sink (input valid, mode, address, data, random_byte, output ready);
endinterface

interface c8ic_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] program_counter;
  logic [2:0]  status;
  logic [7:0]  read_byte;
  logic [63:0] row_pixels;
  logic        sound_on;
  modport source (output valid, program_counter, status, read_byte, row_pixels, sound_on,
                  input ready);
  modport sink (input valid, program_counter, status, read_byte, row_pixels, sound_on,
                output ready);
endinterface

@@ sv/chip8_instruction_core.sv @@
// Top level of the CHIP-8 instruction core: controller, datapath and channel wiring.
//
//   channel   direction  handshake       contents
//   in_ch     input      valid/ready     mode, address, data, random_byte
//   out_ch    output     valid/ready     program_counter, status, read_byte,
//                                         row_pixels, sound_on
//   cfg_*     input      write enable    register index and one data bit
//
// After reset a clearing pass over main memory loads the font and zeroes the rest;
// no item is taken until it ends. One item is handled at a time. A plain instruction
// fetches two bytes and does two register-file reads before execution, through the
// single memory and register-file ports. An instruction that writes VF and 00EE add
// a step, FX33 writes its three digits in turn, FX55/FX65 add a read and a write per
// register and a closing step, and a sprite a read and a write per drawn row and a
// VF write. The result register lets the next item in while a result waits; the core
// stalls only when a new result is ready and the old one is untaken.
module chip8_instruction_core import c8ic_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  c8ic_in_if.sink              in_ch,
  c8ic_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic                 cfg_data
);

  cmd_t     cmd;
  dp_stat_t stat;

  // Sequencer.
  c8ic_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_mode   (in_ch.mode),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Machine state and execution.
  c8ic_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_mode             (in_ch.mode),
    .in_address          (in_ch.address),
    .in_data             (in_ch.data),
    .in_random_byte      (in_ch.random_byte),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .out_program_counter (out_ch.program_counter),
    .out_status          (out_ch.status),
    .out_read_byte       (out_ch.read_byte),
    .out_row_pixels      (out_ch.row_pixels),
    .out_sound_on        (out_ch.sound_on)
  );

endmodule

@@ sv/c8ic_ctrl.sv @@
// Sequencing state machine of the CHIP-8 instruction core.
module c8ic_ctrl import c8ic_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [2:0] in_mode,
  output logic       in_ready,
  input  logic       out_ready,
  output logic       out_valid,
  input  dp_stat_t   stat,
  output cmd_t       cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign out_valid = out_valid_r;

  // State and result-valid registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_nxt     = state_r;
    cmd           = C_NONE;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_CLEAR: begin
        cmd = C_CLEAR;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd = C_LATCH;
          unique case (mode_t'(in_mode))
            MODE_EXEC:                  state_nxt = S_FHI;
            MODE_TICK:                  state_nxt = S_TICK;
            MODE_KEY_DOWN, MODE_KEY_UP: state_nxt = S_KEY;
            MODE_MEM_WR:                state_nxt = S_MWR;
            MODE_MEM_RD:                state_nxt = S_MRD;
            MODE_ROW_RD:                state_nxt = S_FBRD;
            default:                    state_nxt = S_DONE;
          endcase
        end
      end
      S_TICK: begin cmd = C_TICK; state_nxt = S_DONE; end
      S_KEY:  begin cmd = C_KEY;  state_nxt = S_DONE; end
      S_MWR:  begin cmd = C_MWR;  state_nxt = S_DONE; end
      S_MRD:  begin cmd = C_MRD;  state_nxt = S_CAPRB; end
      S_CAPRB: begin cmd = C_CAPRB; state_nxt = S_DONE; end
      S_FBRD: begin cmd = C_FBRD; state_nxt = S_CAPROW; end
      S_CAPROW: begin cmd = C_CAPROW; state_nxt = S_DONE; end
      S_FHI:  begin cmd = C_FHI;  state_nxt = S_FLO; end
      S_FLO:  begin cmd = C_FLO;  state_nxt = S_RX; end
      S_RX:   begin cmd = C_RX;   state_nxt = S_RY; end
      S_RY:   begin cmd = C_RY;   state_nxt = S_EXEC; end
      S_EXEC: begin
        cmd = C_EXEC;
        unique case (stat.kind)
          K_FLAG:   state_nxt = S_WRF;
          K_DRAW:   state_nxt = S_DRD;
          K_BCD:    state_nxt = S_B0;
          K_RET:    state_nxt = S_RET;
          K_BLK_ST: state_nxt = S_K55R;
          K_BLK_LD: state_nxt = S_K65R;
          default:  state_nxt = S_DONE;
        endcase
      end
      S_WRF:  begin cmd = C_WRF; state_nxt = S_DONE; end
      S_RET:  begin cmd = C_RET; state_nxt = S_DONE; end
      S_DRD: begin
        if (stat.draw_end) begin
          state_nxt = S_WRF;
        end else begin
          cmd       = C_DRD;
          state_nxt = S_DWR;
        end
      end
      S_DWR:  begin cmd = C_DWR; state_nxt = S_DRD; end
      S_B0:   begin cmd = C_B0; state_nxt = S_B1; end
      S_B1:   begin cmd = C_B1; state_nxt = S_B2; end
      S_B2:   begin cmd = C_B2; state_nxt = S_DONE; end
      S_K55R: begin cmd = C_K55R; state_nxt = S_K55W; end
      S_K55W: begin
        cmd       = C_K55W;
        state_nxt = stat.loop_last ? S_KEND : S_K55R;
      end
      S_K65R: begin cmd = C_K65R; state_nxt = S_K65W; end
      S_K65W: begin
        cmd       = C_K65W;
        state_nxt = stat.loop_last ? S_KEND : S_K65R;
      end
      S_KEND: begin cmd = C_KEND; state_nxt = S_DONE; end
      S_DONE: begin
        // The result register frees up when its previous item is taken.
        if (!out_valid_r || out_ready) begin
          cmd           = C_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

@@ sv/c8ic_dp.sv @@
// Datapath of the CHIP-8 instruction core: machine state, memories and execution.
module c8ic_dp import c8ic_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output dp_stat_t    stat,
  input  logic [2:0]  in_mode,
  input  logic [11:0] in_address,
  input  logic [7:0]  in_data,
  input  logic [7:0]  in_random_byte,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic                 cfg_data,
  output logic [11:0] out_program_counter,
  output logic [2:0]  out_status,
  output logic [7:0]  out_read_byte,
  output logic [63:0] out_row_pixels,
  output logic        out_sound_on
);

  // Configuration.
  logic reset_vf_r, shift_vx_r, keep_index_r, step_x_r, wrap_r;

  // Latched item and machine registers.
  mode_t             mode_r;
  logic [ADDR_W-1:0] addr_r, pc_r, i_r, clr_r;
  logic [7:0]        data_r, rnd_r, dt_r, snd_r, op_hi_r, vx_r, rb_r;
  logic [DEPTH_W-1:0] depth_r;
  logic [4:0]        held_r;
  logic [KEY_CNT-1:0] keys_r;
  logic [15:0]       op_r;
  logic [3:0]        cnt_r;
  logic              flag_r;
  logic [COL_W-1:0]  xpos_r;
  logic [ROW_W-1:0]  ypos_r;
  status_t           status_r;
  logic [SCR_W-1:0]  row_r;

  // Memories with registered reads.
  logic [7:0]        mem [MEM_BYTES];
  logic [7:0]        mem_q;
  logic [7:0]        rf [REG_CNT];
  logic [REG_CNT-1:0] rf_vld_r;
  logic [7:0]        rf_q;
  logic              rf_vq;
  logic [ADDR_W-1:0] stk [STACK_ENTRIES];
  logic [ADDR_W-1:0] stk_q;
  logic [SCR_W-1:0]  fb [SCR_H];
  logic [SCR_H-1:0]  fb_vld_r;
  logic [SCR_W-1:0]  fb_q;
  logic              fb_vq;

  // Opcode fields.
  logic [3:0]  x, y, n;
  logic [7:0]  nn;
  logic [11:0] nnn;
  assign x   = op_r[11:8];
  assign y   = op_r[7:4];
  assign n   = op_r[3:0];
  assign nn  = op_r[7:0];
  assign nnn = op_r[11:0];

  logic [7:0]       rf_val;
  logic [SCR_W-1:0] fb_val;
  assign rf_val = rf_vq ? rf_q : 8'd0;
  assign fb_val = fb_vq ? fb_q : '0;

  // Sprite row geometry and XOR mask.
  logic [ROW_W:0]     row_idx;
  logic [SCR_W-1:0]   pat, mask;
  logic [2*SCR_W-1:0] rot;
  logic               hit;
  assign row_idx = {1'b0, ypos_r} + {{(ROW_W-3){1'b0}}, cnt_r};
  assign pat     = {mem_q, {(SCR_W-8){1'b0}}};
  assign rot     = {pat, pat} >> xpos_r;
  assign mask    = wrap_r ? rot[SCR_W-1:0] : (pat >> xpos_r);
  assign hit     = |(fb_val & mask);

  // Decimal digits of VX.
  logic [1:0] hund;
  logic [6:0] rem;
  logic [3:0] tens, ones;
  always_comb begin
    hund = (vx_r >= 8'd200) ? 2'd2 : (vx_r >= 8'd100) ? 2'd1 : 2'd0;
    rem  = 7'(vx_r - 8'(hund) * 8'd100);
    tens = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (rem >= 7'(k * 10)) tens = 4'(k);
    end
    ones = 4'(rem - 7'(tens) * 7'd10);
  end

  // Key-wait helpers: lowest pressed key.
  logic       any_key;
  logic [3:0] low_key;
  always_comb begin
    any_key = |keys_r;
    low_key = 4'd0;
    for (int k = KEY_CNT - 1; k >= 0; k--) begin
      if (keys_r[k]) low_key = 4'(k);
    end
  end

  // Combinational decode and effects of the instruction.
  status_t           ex_status;
  kind_t             ex_kind;
  logic [ADDR_W-1:0] ex_pc, ex_i, pc2;
  logic              ex_pc_we, ex_rf_we, ex_flag, ex_i_we, ex_dt_we, ex_snd_we;
  logic              ex_push, ex_pop, ex_cls, ex_held_we;
  logic [7:0]        ex_wd, shv, ex_snd;
  logic [4:0]        ex_held;
  logic [8:0]        sum;

  assign pc2 = pc_r + 12'd2;
  assign sum = {1'b0, vx_r} + {1'b0, rf_val};

  always_comb begin
    ex_status  = ST_OK;
    ex_kind    = K_SIMPLE;
    ex_pc      = pc2;
    ex_pc_we   = 1'b1;
    ex_rf_we   = 1'b0;
    ex_wd      = vx_r;
    ex_flag    = 1'b0;
    ex_i_we    = 1'b0;
    ex_i       = nnn;
    ex_dt_we   = 1'b0;
    ex_snd_we  = 1'b0;
    ex_snd     = (vx_r != 8'd0 && vx_r < 8'd4) ? 8'd4 : vx_r;
    ex_push    = 1'b0;
    ex_pop     = 1'b0;
    ex_cls     = 1'b0;
    ex_held_we = 1'b0;
    ex_held    = any_key ? {1'b0, low_key} : held_r;
    shv        = shift_vx_r ? vx_r : rf_val;
    unique case (op_r[15:12])
      4'h0: begin
        if (op_r == 16'h00E0) begin
          ex_cls = 1'b1;
        end else if (op_r == 16'h00EE) begin
          ex_pc_we = 1'b0;
          if (depth_r == '0) begin
            ex_status = ST_UNDERFLOW;
          end else begin
            ex_kind = K_RET;
            ex_pop  = 1'b1;
          end
        end else begin
          ex_status = ST_UNKNOWN;
          ex_pc_we  = 1'b0;
        end
      end
      4'h1: ex_pc = nnn;
      4'h2: begin
        if (depth_r == DEPTH_W'(STACK_ENTRIES)) begin
          ex_status = ST_OVERFLOW;
          ex_pc_we  = 1'b0;
        end else begin
          ex_push = 1'b1;
          ex_pc   = nnn;
        end
      end
      4'h3: if (vx_r == nn) ex_pc = pc_r + 12'd4;
      4'h4: if (vx_r != nn) ex_pc = pc_r + 12'd4;
      4'h5: if (vx_r == rf_val) ex_pc = pc_r + 12'd4;
      4'h6: begin ex_rf_we = 1'b1; ex_wd = nn; end
      4'h7: begin ex_rf_we = 1'b1; ex_wd = vx_r + nn; end
      4'h8: begin
        ex_rf_we = 1'b1;
        case (n)
          4'h0: ex_wd = rf_val;
          4'h1, 4'h2, 4'h3: begin
            ex_wd   = (n == 4'h1) ? (vx_r | rf_val) :
                      (n == 4'h2) ? (vx_r & rf_val) : (vx_r ^ rf_val);
            ex_kind = reset_vf_r ? K_FLAG : K_SIMPLE;
          end
          4'h4: begin ex_wd = sum[7:0]; ex_flag = sum[8]; ex_kind = K_FLAG; end
          4'h5: begin ex_wd = vx_r - rf_val; ex_flag = vx_r >= rf_val; ex_kind = K_FLAG; end
          4'h6: begin ex_wd = shv >> 1; ex_flag = shv[0]; ex_kind = K_FLAG; end
          4'h7: begin ex_wd = rf_val - vx_r; ex_flag = rf_val >= vx_r; ex_kind = K_FLAG; end
          4'hE: begin ex_wd = shv << 1; ex_flag = shv[7]; ex_kind = K_FLAG; end
          default: begin
            ex_rf_we  = 1'b0;
            ex_status = ST_UNKNOWN;
            ex_pc_we  = 1'b0;
          end
        endcase
      end
      4'h9: if (vx_r != rf_val) ex_pc = pc_r + 12'd4;
      4'hA: ex_i_we = 1'b1;
      4'hB: ex_pc = nnn + {4'd0, rf_val};
      4'hC: begin ex_rf_we = 1'b1; ex_wd = rnd_r & nn; end
      4'hD: ex_kind = K_DRAW;
      4'hE: begin
        if (nn == 8'h9E) begin
          if (keys_r[vx_r[3:0]]) ex_pc = pc_r + 12'd4;
        end else if (nn == 8'hA1) begin
          if (!keys_r[vx_r[3:0]]) ex_pc = pc_r + 12'd4;
        end else begin
          ex_status = ST_UNKNOWN;
          ex_pc_we  = 1'b0;
        end
      end
      default: begin
        case (nn)
          8'h07: begin ex_rf_we = 1'b1; ex_wd = dt_r; end
          8'h0A: begin
            // Completes only once a key has been recorded and all keys have been released.
            ex_held_we = 1'b1;
            if (!any_key && !held_r[4]) begin
              ex_rf_we = 1'b1;
              ex_wd    = {4'd0, held_r[3:0]};
              ex_held  = 5'd16;
            end else begin
              ex_status = ST_KEY_WAIT;
              ex_pc_we  = 1'b0;
            end
          end
          8'h15: ex_dt_we = 1'b1;
          8'h18: ex_snd_we = 1'b1;
          8'h1E: begin ex_i_we = 1'b1; ex_i = i_r + {4'd0, vx_r}; end
          8'h29: begin
            ex_i_we = 1'b1;
            ex_i    = {6'd0, vx_r[3:0], 2'd0} + {8'd0, vx_r[3:0]};
          end
          8'h30: ex_pc_we = 1'b0;
          8'h33: ex_kind = K_BCD;
          8'h55: ex_kind = K_BLK_ST;
          8'h65: ex_kind = K_BLK_LD;
          default: begin
            ex_status = ST_UNKNOWN;
            ex_pc_we  = 1'b0;
          end
        endcase
      end
    endcase
  end

  // Status towards the controller.
  assign stat.clr_last  = (clr_r == ADDR_W'(MEM_BYTES - 1));
  assign stat.kind      = ex_kind;
  assign stat.draw_end  = (cnt_r == n) || (!wrap_r && row_idx[ROW_W]);
  assign stat.loop_last = (cnt_r == x);

  // Main memory port selection.
  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa, mem_ra, i_cnt;
  logic [7:0]        mem_wd;
  assign i_cnt = i_r + {8'd0, cnt_r};
  always_comb begin
    mem_we = 1'b0;
    mem_wa = addr_r;
    mem_wd = data_r;
    mem_ra = addr_r;
    case (cmd)
      C_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_r;
        mem_wd = (clr_r < ADDR_W'(FONT_BYTES)) ? FONT[clr_r[6:0]] : 8'd0;
      end
      C_MWR:         mem_we = 1'b1;
      C_FHI:         mem_ra = pc_r;
      C_FLO:         mem_ra = pc_r + 12'd1;
      C_DRD, C_K65R: mem_ra = i_cnt;
      C_B0: begin mem_we = 1'b1; mem_wa = i_r;          mem_wd = {6'd0, hund}; end
      C_B1: begin mem_we = 1'b1; mem_wa = i_r + 12'd1;  mem_wd = {4'd0, tens}; end
      C_B2: begin mem_we = 1'b1; mem_wa = i_r + 12'd2;  mem_wd = {4'd0, ones}; end
      C_K55W: begin mem_we = 1'b1; mem_wa = i_cnt; mem_wd = rf_val; end
      default: ;
    endcase
  end

  // Register file port selection.
  logic       rf_we;
  logic [3:0] rf_wa, rf_ra;
  logic [7:0] rf_wd;
  always_comb begin
    rf_we = 1'b0;
    rf_wa = x;
    rf_wd = ex_wd;
    rf_ra = x;
    case (cmd)
      C_RX:   rf_ra = op_hi_r[3:0];
      C_RY:   rf_ra = (op_r[15:12] == 4'hB) ? 4'h0 : y;
      C_K55R: rf_ra = cnt_r;
      C_EXEC: rf_we = ex_rf_we;
      C_WRF: begin rf_we = 1'b1; rf_wa = 4'hF; rf_wd = {7'd0, flag_r}; end
      C_K65W: begin rf_we = 1'b1; rf_wa = cnt_r; rf_wd = mem_q; end
      default: ;
    endcase
  end

  logic [ROW_W-1:0] fb_ra;
  assign fb_ra = (cmd == C_FBRD) ? addr_r[ROW_W-1:0] : row_idx[ROW_W-1:0];

  // Memory arrays.
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_q <= mem[mem_ra];
    if (rf_we) rf[rf_wa] <= rf_wd;
    rf_q  <= rf[rf_ra];
    rf_vq <= rf_vld_r[rf_ra];
    if (cmd == C_EXEC && ex_push) stk[depth_r[STK_W-1:0]] <= pc2;
    stk_q <= stk[depth_r[STK_W-1:0] - 1'b1];
    if (cmd == C_DWR) fb[row_idx[ROW_W-1:0]] <= fb_val ^ mask;
    fb_q  <= fb[fb_ra];
    fb_vq <= fb_vld_r[fb_ra];
  end

  // Machine state and item registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reset_vf_r   <= 1'b0;
      shift_vx_r   <= 1'b0;
      keep_index_r <= 1'b0;
      step_x_r     <= 1'b0;
      wrap_r       <= 1'b0;
      clr_r        <= '0;
      pc_r         <= PC_RESET;
      i_r          <= '0;
      dt_r         <= 8'd0;
      snd_r        <= 8'd0;
      depth_r      <= '0;
      held_r       <= 5'd16;
      keys_r       <= '0;
      rf_vld_r     <= '0;
      fb_vld_r     <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_RESET_VF:   reset_vf_r   <= cfg_data;
          CFG_SHIFT_VX:   shift_vx_r   <= cfg_data;
          CFG_KEEP_INDEX: keep_index_r <= cfg_data;
          CFG_STEP_X:     step_x_r     <= cfg_data;
          CFG_WRAP:       wrap_r       <= cfg_data;
          default: ;
        endcase
      end
      if (rf_we) rf_vld_r[rf_wa] <= 1'b1;
      case (cmd)
        C_CLEAR: clr_r <= clr_r + 1'b1;
        C_LATCH: begin
          mode_r   <= mode_t'(in_mode);
          addr_r   <= in_address;
          data_r   <= in_data;
          rnd_r    <= in_random_byte;
          status_r <= ST_OK;
          rb_r     <= 8'd0;
          row_r    <= '0;
        end
        C_TICK: begin
          if (dt_r != 8'd0) dt_r <= dt_r - 8'd1;
          if (snd_r != 8'd0) snd_r <= snd_r - 8'd1;
        end
        C_KEY:    keys_r[data_r[3:0]] <= (mode_r == MODE_KEY_DOWN);
        C_CAPRB:  rb_r <= mem_q;
        C_CAPROW: row_r <= (addr_r[ADDR_W-1:ROW_W] == '0) ? fb_val : '0;
        C_FLO:    op_hi_r <= mem_q;
        C_RX:     op_r <= {op_hi_r, mem_q};
        C_RY:     vx_r <= rf_val;
        C_EXEC: begin
          xpos_r   <= vx_r[COL_W-1:0];
          ypos_r   <= rf_val[ROW_W-1:0];
          cnt_r    <= 4'd0;
          flag_r   <= ex_flag;
          status_r <= ex_status;
          if (ex_pc_we)   pc_r    <= ex_pc;
          if (ex_i_we)    i_r     <= ex_i;
          if (ex_dt_we)   dt_r    <= vx_r;
          if (ex_snd_we)  snd_r   <= ex_snd;
          if (ex_push)    depth_r <= depth_r + 1'b1;
          if (ex_pop)     depth_r <= depth_r - 1'b1;
          if (ex_cls)     fb_vld_r <= '0;
          if (ex_held_we) held_r  <= ex_held;
        end
        C_RET: pc_r <= stk_q;
        C_DWR: begin
          flag_r <= flag_r | hit;
          cnt_r  <= cnt_r + 4'd1;
          fb_vld_r[row_idx[ROW_W-1:0]] <= 1'b1;
        end
        C_K55W, C_K65W: cnt_r <= cnt_r + 4'd1;
        C_KEND: begin
          if (!keep_index_r) i_r <= i_r + {8'd0, x} + {11'd0, ~step_x_r};
        end
        C_OUT: begin
          out_program_counter <= pc_r;
          out_status          <= status_r;
          out_read_byte       <= rb_r;
          out_row_pixels      <= row_r;
          out_sound_on        <= (snd_r != 8'd0);
        end
        default: ;
      endcase
    end
  end

endmodule
